// ===== sv/mbs_pkg.sv =====
// shared types, codes and crc helper for the modbus rtu sniffer frame parser
package mbs_pkg;

  localparam logic [7:0] FN_READ         = 8'h03;
  localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;

  localparam logic [2:0] ST_BUSY        = 3'd0;
  localparam logic [2:0] ST_NO_RESPONSE = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT   = 3'd2;
  localparam logic [2:0] ST_CRC_BAD     = 3'd3;
  localparam logic [2:0] ST_EXCEPTION   = 3'd4;
  localparam logic [2:0] ST_WRITE_MULTI = 3'd5;
  localparam logic [2:0] ST_WRITE_SGL   = 3'd6;
  localparam logic [2:0] ST_READ_OK     = 3'd7;

  localparam logic [1:0] DIR_UNKNOWN  = 2'd0;
  localparam logic [1:0] DIR_RESPONSE = 2'd1;
  localparam logic [1:0] DIR_REQUEST  = 2'd2;

  localparam logic       MODE_BYTE    = 1'b0;
  localparam logic       MODE_TIMEOUT = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hffff;
  localparam logic [15:0] CRC_POLY = 16'ha001;

  typedef struct packed {
    logic       data_valid;
    logic [8:0] data_index;
    logic [7:0] data_value;
    logic       frame_done;
    logic [2:0] status;
    logic [7:0] function_code;
    logic [7:0] data_size;
    logic [1:0] direction;
  } mbs_result_t;

  // crc-16/modbus, one byte, reflected
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // byte counts that can only belong to a read response
  function automatic logic is_plain_count(input logic [7:0] b);
    return (b inside {8'h02, 8'h03, 8'h05, [8'h09:8'h0f]}) || (b >= 8'h11);
  endfunction

  // byte counts that may also be the start address high byte of a request
  function automatic logic is_ambiguous_count(input logic [7:0] b);
    return b inside {8'h04, 8'h06, 8'h08, 8'h10};
  endfunction

endpackage

// ===== sv/modbus_rtu_sniffer_frame_parser.sv =====
// Passive Modbus RTU frame parser for sniffed bus bytes. Each input transfer is one received
// byte or a line-silent event and yields exactly one result transfer: the payload byte if the
// item stored one, and the frame status when a frame ends (by its expected length or on
// silence), with a CRC-16/Modbus check over all received bytes of the frame. The block takes
// one item per clock cycle while the output is not stalled; each result passes through the input
// register, then the byte-wide CRC update and position compare into the result register.
// A stalled output holds both registers and drops in_ready. slave_address is written through
// cfg_we/cfg_wdata and resets to 1; it should only change while no item is in flight.
module modbus_rtu_sniffer_frame_parser #(
  parameter int MULTI_COUNT_POSITION = 6,
  parameter int MIN_LAST_POSITION    = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_data_valid,
  output logic [8:0] out_data_index,
  output logic [7:0] out_data_value,
  output logic       out_frame_done,
  output logic [2:0] out_status,
  output logic [7:0] out_function_code,
  output logic [7:0] out_data_size,
  output logic [1:0] out_direction
);

  logic [7:0]           slave_address_r;
  logic                 in_valid_r;
  logic                 in_mode_r;
  logic [7:0]           in_byte_r;
  logic                 out_valid_r;
  mbs_pkg::mbs_result_t out_r;
  mbs_pkg::mbs_result_t core_res;
  logic                 advance;
  logic                 step;

  assign advance  = !out_valid_r || out_ready;
  assign step     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= 8'd1;
    end else if (cfg_we) begin
      slave_address_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_mode_r <= in_mode;
      in_byte_r <= in_byte_value;
    end
  end

  mbs_frame_core #(
    .MULTI_COUNT_POSITION(MULTI_COUNT_POSITION),
    .MIN_LAST_POSITION   (MIN_LAST_POSITION)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .mode         (in_mode_r),
    .byte_value   (in_byte_r),
    .slave_address(slave_address_r),
    .result       (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= core_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_valid    = out_r.data_valid;
  assign out_data_index    = out_r.data_index;
  assign out_data_value    = out_r.data_value;
  assign out_frame_done    = out_r.frame_done;
  assign out_status        = out_r.status;
  assign out_function_code = out_r.function_code;
  assign out_data_size     = out_r.data_size;
  assign out_direction     = out_r.direction;

endmodule

// ===== sv/mbs_frame_core.sv =====
// frame state, crc and direction guessing, one item per step
module mbs_frame_core #(
  parameter int MULTI_COUNT_POSITION = 6,
  parameter int MIN_LAST_POSITION    = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 mode,
  input  logic [7:0]           byte_value,
  input  logic [7:0]           slave_address,
  output mbs_pkg::mbs_result_t result
);

  localparam logic [8:0] MIN_LAST  = 9'(MIN_LAST_POSITION);
  localparam logic [8:0] MULTI_POS = 9'(MULTI_COUNT_POSITION);

  logic [8:0]  pos_r, pos_nxt;
  logic [8:0]  last_r, last_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [1:0]  dir_r, dir_nxt;
  logic [7:0]  size_r, size_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        seen_r, seen_nxt;
  logic        prv_rd_r, prv_rd_nxt;
  logic        prv_sg_r, prv_sg_nxt;
  logic        prv_mu_r, prv_mu_nxt;

  logic        end_now;
  logic [8:0]  last_idx;
  logic        known;
  logic [15:0] crc_step;

  assign crc_step = mbs_pkg::crc16_byte((pos_r == 9'd0) ? mbs_pkg::CRC_INIT : crc_r, byte_value);

  always_comb begin
    pos_nxt    = pos_r;
    last_nxt   = last_r;
    func_nxt   = func_r;
    dir_nxt    = dir_r;
    size_nxt   = size_r;
    crc_nxt    = crc_r;
    seen_nxt   = seen_r;
    prv_rd_nxt = prv_rd_r;
    prv_sg_nxt = prv_sg_r;
    prv_mu_nxt = prv_mu_r;
    end_now    = 1'b0;
    last_idx   = 9'd0;
    known      = 1'b0;
    result     = '0;

    if (mode == mbs_pkg::MODE_TIMEOUT) begin
      prv_rd_nxt = 1'b0;
      prv_sg_nxt = 1'b0;
      prv_mu_nxt = 1'b0;
      result.frame_done = 1'b1;
      if (pos_r == 9'd0) begin
        result.status = mbs_pkg::ST_NO_RESPONSE;
        func_nxt = 8'd0;
        size_nxt = 8'd0;
        dir_nxt  = mbs_pkg::DIR_UNKNOWN;
        last_nxt = MIN_LAST;
        crc_nxt  = mbs_pkg::CRC_INIT;
        seen_nxt = 1'b0;
      end else begin
        end_now = 1'b1;
      end
    end else if (pos_r == 9'd0) begin
      // hunting: only our address opens a frame
      if (byte_value == slave_address) begin
        func_nxt = 8'd0;
        size_nxt = 8'd0;
        dir_nxt  = mbs_pkg::DIR_UNKNOWN;
        last_nxt = MIN_LAST;
        seen_nxt = 1'b0;
        crc_nxt  = crc_step;
        pos_nxt  = 9'd1;
      end
    end else begin
      crc_nxt = crc_step;
      if (pos_r == 9'd1) begin
        func_nxt = byte_value;
        if (byte_value == mbs_pkg::FN_WRITE_SINGLE) begin
          dir_nxt    = prv_sg_r ? mbs_pkg::DIR_RESPONSE : mbs_pkg::DIR_REQUEST;
          prv_sg_nxt = !prv_sg_r;
          last_nxt   = 9'd7;
          size_nxt   = 8'd4;
          prv_rd_nxt = 1'b0;
          prv_mu_nxt = 1'b0;
        end else if (byte_value == mbs_pkg::FN_WRITE_MULTI) begin
          last_nxt   = 9'd7;
          size_nxt   = 8'd4;
          prv_rd_nxt = 1'b0;
          prv_sg_nxt = 1'b0;
        end else if (byte_value != mbs_pkg::FN_READ) begin
          size_nxt   = 8'd1;
          last_nxt   = MIN_LAST + 9'd1;
          prv_rd_nxt = 1'b0;
          prv_sg_nxt = 1'b0;
          prv_mu_nxt = 1'b0;
        end
      end else if (pos_r == 9'd2 && func_r == mbs_pkg::FN_READ) begin
        if (mbs_pkg::is_plain_count(byte_value) ||
            (prv_rd_r && mbs_pkg::is_ambiguous_count(byte_value))) begin
          dir_nxt    = mbs_pkg::DIR_RESPONSE;
          size_nxt   = byte_value;
          last_nxt   = {1'b0, byte_value} + 9'd4;
          prv_rd_nxt = 1'b0;
        end else begin
          // request: start address high byte is payload byte 0
          dir_nxt    = mbs_pkg::DIR_REQUEST;
          size_nxt   = 8'd4;
          last_nxt   = 9'd7;
          prv_rd_nxt = 1'b1;
          result.data_valid = 1'b1;
          result.data_value = byte_value;
        end
        prv_sg_nxt = 1'b0;
        prv_mu_nxt = 1'b0;
      end else begin
        if (func_r == mbs_pkg::FN_WRITE_MULTI && pos_r == MULTI_POS) begin
          // request byte count of 2 or 4 unless a request was just seen, else the slave echo
          if (!prv_mu_r && byte_value == 8'd2) begin
            size_nxt   = 8'd7;
            last_nxt   = 9'd10;
            dir_nxt    = mbs_pkg::DIR_REQUEST;
            prv_mu_nxt = 1'b1;
          end else if (!prv_mu_r && byte_value == 8'd4) begin
            size_nxt   = 8'd9;
            last_nxt   = 9'd12;
            dir_nxt    = mbs_pkg::DIR_REQUEST;
            prv_mu_nxt = 1'b1;
          end else begin
            dir_nxt    = mbs_pkg::DIR_RESPONSE;
            prv_mu_nxt = 1'b0;
          end
        end
        seen_nxt = 1'b1;
        result.data_valid = 1'b1;
        result.data_value = byte_value;
        if (func_r == mbs_pkg::FN_READ && dir_nxt == mbs_pkg::DIR_RESPONSE) begin
          result.data_index = pos_r - 9'd3;
        end else begin
          result.data_index = pos_r - 9'd2;
        end
      end
      pos_nxt = pos_r + 9'd1;
      if (pos_nxt > last_nxt) begin
        end_now = 1'b1;
        result.frame_done = 1'b1;
      end
    end

    if (end_now) begin
      last_idx = pos_nxt - 9'd1;
      known = func_nxt == mbs_pkg::FN_READ || func_nxt == mbs_pkg::FN_WRITE_SINGLE ||
              func_nxt == mbs_pkg::FN_WRITE_MULTI;
      if (!known && seen_nxt && last_idx > MIN_LAST) begin
        size_nxt = 8'd2;
      end
      if (last_idx < MIN_LAST) begin
        result.status = mbs_pkg::ST_TOO_SHORT;
      end else if (crc_nxt != 16'd0) begin
        result.status = mbs_pkg::ST_CRC_BAD;
      end else if (func_nxt == mbs_pkg::FN_WRITE_MULTI) begin
        result.status = mbs_pkg::ST_WRITE_MULTI;
      end else if (func_nxt == mbs_pkg::FN_WRITE_SINGLE) begin
        result.status = mbs_pkg::ST_WRITE_SGL;
      end else if (func_nxt == mbs_pkg::FN_READ) begin
        result.status = mbs_pkg::ST_READ_OK;
      end else begin
        result.status = mbs_pkg::ST_EXCEPTION;
      end
      pos_nxt  = 9'd0;
      last_nxt = MIN_LAST;
      crc_nxt  = mbs_pkg::CRC_INIT;
      seen_nxt = 1'b0;
    end

    result.function_code = func_nxt;
    result.data_size     = size_nxt;
    result.direction     = dir_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 9'd0;
      last_r   <= MIN_LAST;
      func_r   <= 8'd0;
      dir_r    <= mbs_pkg::DIR_UNKNOWN;
      size_r   <= 8'd0;
      crc_r    <= mbs_pkg::CRC_INIT;
      seen_r   <= 1'b0;
      prv_rd_r <= 1'b0;
      prv_sg_r <= 1'b0;
      prv_mu_r <= 1'b0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      last_r   <= last_nxt;
      func_r   <= func_nxt;
      dir_r    <= dir_nxt;
      size_r   <= size_nxt;
      crc_r    <= crc_nxt;
      seen_r   <= seen_nxt;
      prv_rd_r <= prv_rd_nxt;
      prv_sg_r <= prv_sg_nxt;
      prv_mu_r <= prv_mu_nxt;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the modbus rtu sniffer frame parser: random frames against a scoreboard
`timescale 1ns / 1ps

class frame_tracker;
  localparam logic [8:0] MIN_LAST  = 9'd4;
  localparam logic [8:0] MULTI_POS = 9'd6;

  logic [7:0]  addr;
  logic [8:0]  pos;
  logic [8:0]  last;
  logic [7:0]  fn;
  logic [1:0]  dir;
  logic [7:0]  size;
  logic [15:0] crc;
  bit          seen_payload;
  bit          read_req_seen;
  bit          single_req_seen;
  bit          multi_req_seen;

  mbs_pkg::mbs_result_t pending[$];
  int          errors;
  int          checked;

  function new();
    addr = 8'h01;
    fn = '0;
    dir = mbs_pkg::DIR_UNKNOWN;
    size = '0;
    read_req_seen = 0;
    single_req_seen = 0;
    multi_req_seen = 0;
    errors = 0;
    checked = 0;
    restart();
  endfunction

  function void set_address(logic [7:0] a);
    addr = a;
  endfunction

  // reflected crc-16, one data bit at a time
  static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
    logic [15:0] v;
    logic        fb;
    v = c;
    for (int i = 0; i < 8; i++) begin
      fb = v[0] ^ b[i];
      v = v >> 1;
      if (fb) v = v ^ mbs_pkg::CRC_POLY;
    end
    return v;
  endfunction

  static function bit response_count(logic [7:0] b);
    case (b)
      8'h02, 8'h03, 8'h05: return 1;
      default: return (b >= 8'h09 && b <= 8'h0f) || b >= 8'h11;
    endcase
  endfunction

  // counts that also look like a start address high byte
  static function bit shared_count(logic [7:0] b);
    case (b)
      8'h04, 8'h06, 8'h08, 8'h10: return 1;
      default: return 0;
    endcase
  endfunction

  function void restart();
    pos = '0;
    last = MIN_LAST;
    crc = mbs_pkg::CRC_INIT;
    seen_payload = 0;
  endfunction

  function logic [2:0] close_frame();
    logic [8:0] last_idx;
    bit         known;
    logic [2:0] st;
    last_idx = pos - 9'd1;
    known = fn == mbs_pkg::FN_READ || fn == mbs_pkg::FN_WRITE_SINGLE ||
            fn == mbs_pkg::FN_WRITE_MULTI;
    if (!known && seen_payload && last_idx > MIN_LAST) size = 8'd2;
    if (last_idx < MIN_LAST) st = mbs_pkg::ST_TOO_SHORT;
    else if (crc != 16'h0000) st = mbs_pkg::ST_CRC_BAD;
    else if (fn == mbs_pkg::FN_WRITE_MULTI) st = mbs_pkg::ST_WRITE_MULTI;
    else if (fn == mbs_pkg::FN_WRITE_SINGLE) st = mbs_pkg::ST_WRITE_SGL;
    else if (fn == mbs_pkg::FN_READ) st = mbs_pkg::ST_READ_OK;
    else st = mbs_pkg::ST_EXCEPTION;
    restart();
    return st;
  endfunction

  function void note_input(logic mode, logic [7:0] b);
    mbs_pkg::mbs_result_t r;
    logic [8:0]  p;
    r = '0;
    if (mode == mbs_pkg::MODE_TIMEOUT) begin
      read_req_seen = 0;
      single_req_seen = 0;
      multi_req_seen = 0;
      r.frame_done = 1'b1;
      if (pos == 9'd0) begin
        r.status = mbs_pkg::ST_NO_RESPONSE;
        fn = '0;
        size = '0;
        dir = mbs_pkg::DIR_UNKNOWN;
        restart();
      end else begin
        r.status = close_frame();
      end
    end else if (pos == 9'd0) begin
      if (b == addr) begin
        restart();
        fn = '0;
        size = '0;
        dir = mbs_pkg::DIR_UNKNOWN;
        crc = crc_next(crc, b);
        pos = 9'd1;
      end
    end else begin
      p = pos;
      crc = crc_next(crc, b);
      if (p == 9'd1) begin
        fn = b;
        if (b == mbs_pkg::FN_WRITE_SINGLE) begin
          dir = single_req_seen ? mbs_pkg::DIR_RESPONSE : mbs_pkg::DIR_REQUEST;
          single_req_seen = !single_req_seen;
          last = 9'd7;
          size = 8'd4;
          read_req_seen = 0;
          multi_req_seen = 0;
        end else if (b == mbs_pkg::FN_WRITE_MULTI) begin
          last = 9'd7;
          size = 8'd4;
          read_req_seen = 0;
          single_req_seen = 0;
        end else if (b != mbs_pkg::FN_READ) begin
          size = 8'd1;
          last = MIN_LAST + 9'd1;
          read_req_seen = 0;
          single_req_seen = 0;
          multi_req_seen = 0;
        end
      end else if (p == 9'd2 && fn == mbs_pkg::FN_READ) begin
        if (response_count(b) || (read_req_seen && shared_count(b))) begin
          dir = mbs_pkg::DIR_RESPONSE;
          size = b;
          last = {1'b0, b} + 9'd4;
          read_req_seen = 0;
        end else begin
          // request: this byte is the start address high byte
          dir = mbs_pkg::DIR_REQUEST;
          size = 8'd4;
          last = 9'd7;
          read_req_seen = 1;
          r.data_valid = 1'b1;
          r.data_index = '0;
          r.data_value = b;
        end
        single_req_seen = 0;
        multi_req_seen = 0;
      end else begin
        if (fn == mbs_pkg::FN_WRITE_MULTI && p == MULTI_POS) begin
          if (!multi_req_seen && b == 8'd2) begin
            size = 8'd7;
            last = 9'd10;
            dir = mbs_pkg::DIR_REQUEST;
            multi_req_seen = 1;
          end else if (!multi_req_seen && b == 8'd4) begin
            size = 8'd9;
            last = 9'd12;
            dir = mbs_pkg::DIR_REQUEST;
            multi_req_seen = 1;
          end else begin
            dir = mbs_pkg::DIR_RESPONSE;
            multi_req_seen = 0;
          end
        end
        seen_payload = 1;
        r.data_valid = 1'b1;
        r.data_value = b;
        r.data_index = (fn == mbs_pkg::FN_READ && dir == mbs_pkg::DIR_RESPONSE) ?
                       p - 9'd3 : p - 9'd2;
      end
      pos = p + 9'd1;
      if (pos > last) begin
        r.frame_done = 1'b1;
        r.status = close_frame();
      end
    end
    r.function_code = fn;
    r.data_size = size;
    r.direction = dir;
    pending.push_back(r);
  endfunction

  task report(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t ns result %0d: %s is %0h, expected %0h", $time, checked, what, got, want);
    errors++;
  endtask

  task check_result(mbs_pkg::mbs_result_t got);
    mbs_pkg::mbs_result_t want;
    if (pending.size() == 0) begin
      report("result with nothing pending", 16'(got), 16'h0000);
    end else begin
      want = pending.pop_front();
      if (got.data_valid !== want.data_valid)
        report("data_valid", 16'(got.data_valid), 16'(want.data_valid));
      if (got.data_index !== want.data_index)
        report("data_index", 16'(got.data_index), 16'(want.data_index));
      if (got.data_value !== want.data_value)
        report("data_value", 16'(got.data_value), 16'(want.data_value));
      if (got.frame_done !== want.frame_done)
        report("frame_done", 16'(got.frame_done), 16'(want.frame_done));
      if (got.status !== want.status)
        report("status", 16'(got.status), 16'(want.status));
      if (got.function_code !== want.function_code)
        report("function_code", 16'(got.function_code), 16'(want.function_code));
      if (got.data_size !== want.data_size)
        report("data_size", 16'(got.data_size), 16'(want.data_size));
      if (got.direction !== want.direction)
        report("direction", 16'(got.direction), 16'(want.direction));
    end
    checked++;
  endtask
endclass

module tb;
  localparam int MULTI_COUNT_POSITION = 6;
  localparam int MIN_LAST_POSITION    = 4;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 195;
  localparam int SETTLE      = 8;
  localparam int LONG_HOLD   = 400;
  localparam int QUIET_LIMIT = 3000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_mode = mbs_pkg::MODE_BYTE;
  logic [7:0] in_byte_value = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_data_valid;
  logic [8:0] out_data_index;
  logic [7:0] out_data_value;
  logic       out_frame_done;
  logic [2:0] out_status;
  logic [7:0] out_function_code;
  logic [7:0] out_data_size;
  logic [1:0] out_direction;

  frame_tracker tracker = new();
  mbs_pkg::mbs_result_t seen;
  logic [8:0]   stim_q[$];
  logic [7:0]   frame_q[$];
  int           counted;
  int           quiet;
  bit           send_calm;
  bit           recv_calm;
  bit           long_hold;

  modbus_rtu_sniffer_frame_parser #(
    .MULTI_COUNT_POSITION(MULTI_COUNT_POSITION),
    .MIN_LAST_POSITION(MIN_LAST_POSITION)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_byte_value(in_byte_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data_valid(out_data_valid),
    .out_data_index(out_data_index),
    .out_data_value(out_data_value),
    .out_frame_done(out_frame_done),
    .out_status(out_status),
    .out_function_code(out_function_code),
    .out_data_size(out_data_size),
    .out_direction(out_direction)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function void push_byte(logic [7:0] b);
    stim_q.push_back({mbs_pkg::MODE_BYTE, b});
  endfunction

  // the byte lane is don't-care on silence, so it carries noise
  function void push_timeout();
    stim_q.push_back({mbs_pkg::MODE_TIMEOUT, 8'($urandom)});
  endfunction

  function void finish_frame(bit with_crc, bit corrupt, bit cut, bit then_timeout);
    logic [15:0] c;
    int          n;
    int          k;
    if (with_crc) begin
      c = mbs_pkg::CRC_INIT;
      foreach (frame_q[i]) c = tracker.crc_next(c, frame_q[i]);
      frame_q.push_back(c[7:0]);
      frame_q.push_back(c[15:8]);
    end
    if (corrupt) begin
      k = $urandom_range(0, frame_q.size() - 1);
      frame_q[k] = frame_q[k] ^ 8'(1 << $urandom_range(0, 7));
    end
    if (cut && frame_q.size() > 1) begin
      n = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > n) void'(frame_q.pop_back());
    end
    foreach (frame_q[i]) push_byte(frame_q[i]);
    counted += frame_q.size();
    if (then_timeout) begin
      push_timeout();
      counted++;
    end
  endfunction

  function logic [7:0] shared_byte();
    case ($urandom_range(0, 3))
      0: return 8'h04;
      1: return 8'h06;
      2: return 8'h08;
      default: return 8'h10;
    endcase
  endfunction

  function void random_frame(logic [7:0] addr);
    int kind;
    int n;
    int r;
    frame_q = {};
    frame_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : addr);
    kind = $urandom_range(0, 99);
    if (kind < 18) begin
      frame_q.push_back(mbs_pkg::FN_READ);
      frame_q.push_back($urandom_range(0, 1) ? shared_byte() : 8'($urandom));
      repeat (3) frame_q.push_back(8'($urandom));
    end else if (kind < 40) begin
      frame_q.push_back(mbs_pkg::FN_READ);
      n = ($urandom_range(0, 14) == 0) ? $urandom_range(200, 255) : $urandom_range(1, 12);
      frame_q.push_back(8'(n));
      repeat (n) frame_q.push_back(8'($urandom));
    end else if (kind < 55) begin
      frame_q.push_back(mbs_pkg::FN_WRITE_SINGLE);
      repeat (4) frame_q.push_back(8'($urandom));
    end else if (kind < 68) begin
      frame_q.push_back(mbs_pkg::FN_WRITE_MULTI);
      repeat (4) frame_q.push_back(8'($urandom));
      r = $urandom_range(0, 9);
      n = (r < 4) ? 2 : (r < 8) ? 4 : $urandom_range(1, 6);
      frame_q.push_back(8'(n));
      repeat (n) frame_q.push_back(8'($urandom));
    end else if (kind < 80) begin
      frame_q.push_back(mbs_pkg::FN_WRITE_MULTI);
      repeat (4) frame_q.push_back(8'($urandom));
    end else begin
      frame_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                   : 8'h80 | 8'($urandom_range(1, 127)));
      frame_q.push_back(8'($urandom));
      if ($urandom_range(0, 4) == 0) frame_q.push_back(8'($urandom));
    end
    r = $urandom_range(0, 99);
    finish_frame(1, r < 8, r >= 8 && r < 16, $urandom_range(0, 99) < 70);
  endfunction

  task send_item(logic m, logic [7:0] b);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_byte_value <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task send_all();
    logic [8:0] item;
    while (stim_q.size() > 0) begin
      item = stim_q.pop_front();
      send_item(item[8], item[7:0]);
    end
    in_valid <= 1'b0;
  endtask

  task drain();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_address(logic [7:0] a);
    cfg_we <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_address(a);
  endtask

  // result side: random back-pressure, one long hold-off on request
  initial begin
    int gap;
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 0;
      end else begin
        gap = pick_gap(recv_calm);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_input(in_mode, in_byte_value);
      if (out_valid && out_ready) begin
        seen.data_valid = out_data_valid;
        seen.data_index = out_data_index;
        seen.data_value = out_data_value;
        seen.frame_done = out_frame_done;
        seen.status = out_status;
        seen.function_code = out_function_code;
        seen.data_size = out_data_size;
        seen.direction = out_direction;
        tracker.check_result(seen);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] addr_plan[PHASES];
    logic [7:0] a;
    int         k;
    addr_plan = '{8'h00, 8'hff, 8'h01, 8'h5a, 8'h03, 8'h80, 8'h10, 8'h2c};
    quiet = 0;
    send_calm = 0;
    recv_calm = 0;
    long_hold = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames at the reset address
    counted = 0;
    push_timeout();
    push_byte(8'h55);
    frame_q = {8'h01, mbs_pkg::FN_WRITE_SINGLE, 8'h00, 8'hff, 8'hff, 8'h00};
    finish_frame(1, 0, 0, 0);
    frame_q = {8'h01, mbs_pkg::FN_READ, 8'h02, 8'h12, 8'h34};
    finish_frame(1, 0, 0, 0);
    frame_q = {8'h01, 8'h83, 8'h02};
    finish_frame(1, 0, 0, 1);
    // read request cut short: count byte is payload byte 0
    frame_q = {8'h01, mbs_pkg::FN_READ, 8'h00};
    finish_frame(0, 0, 0, 1);
    send_all();
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      a = (ph == 3 || ph == 5 || ph == 7) ? 8'($urandom) : addr_plan[ph];
      write_address(a);
      send_calm = (ph == 2 || ph == 5);
      recv_calm = (ph == 2 || ph == 6);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        k = $urandom_range(0, 99);
        if (k < 6) begin
          repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
        end else if (k < 12) begin
          push_timeout();
          counted++;
        end else begin
          random_frame(a);
        end
      end
      if (ph == 3) long_hold = 1;
      send_all();
      drain();
    end

    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
